// ----- rtl/ipc_pkg.sv -----
// Shared types, constants and helper functions of the isolated pixel check unit.
package ipc_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
	localparam int FW_W         = 11;
	localparam int FH_W         = 13;
	localparam int DATA_W       = 32;
	localparam int PADDR_W      = 3;
	localparam int OBUF_DEPTH   = 3;
	localparam int OBUF_CNT_W   = $clog2(OBUF_DEPTH + 1);

	localparam logic [FW_W-1:0] FW_RESET = FW_W'(1024);
	localparam logic [FH_W-1:0] FH_RESET = FH_W'(1024);

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic             restart;
		logic [COL_W-1:0] wm1;
		logic [ROW_W-1:0] hm1;
	} cfg_t;

	typedef struct packed {
		logic vld;
		logic all_connected;
	} res_t;

	// Last column index for a programmed width; zero counts as one column.
	function automatic logic [COL_W-1:0] eff_width_m1(input logic [FW_W-1:0] w);
		if (w == '0) begin
			return '0;
		end else if (w > FW_W'(MAX_WIDTH)) begin
			return COL_W'(MAX_WIDTH - 1);
		end else begin
			return COL_W'(w - 1'b1);
		end
	endfunction

	// Last row index for a programmed height; zero counts as one row.
	function automatic logic [ROW_W-1:0] eff_height_m1(input logic [FH_W-1:0] h);
		if (h == '0) begin
			return '0;
		end else if (h > FH_W'(HEIGHT_LIMIT)) begin
			return ROW_W'(HEIGHT_LIMIT - 1);
		end else begin
			return ROW_W'(h - 1'b1);
		end
	endfunction

endpackage

// ----- rtl/ipc_cfg_regs.sv -----
// Frame size registers behind the APB-style configuration port.
module ipc_cfg_regs import ipc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic             wr_en;
	reg_idx_t         idx;
	logic [FW_W-1:0]  width_q;
	logic [FH_W-1:0]  height_q;
	logic [COL_W-1:0] wm1_q;
	logic [ROW_W-1:0] hm1_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FW_RESET;
			height_q <= FH_RESET;
			wm1_q    <= eff_width_m1(FW_RESET);
			hm1_q    <= eff_height_m1(FH_RESET);
		end else if (wr_en) begin
			case (idx)
				REG_FRAME_WIDTH: begin
					width_q <= pwdata[FW_W-1:0];
					wm1_q   <= eff_width_m1(pwdata[FW_W-1:0]);
				end
				REG_FRAME_HEIGHT: begin
					height_q <= pwdata[FH_W-1:0];
					hm1_q    <= eff_height_m1(pwdata[FH_W-1:0]);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FRAME_WIDTH:  prdata = {{(DATA_W - FW_W){1'b0}}, width_q};
			REG_FRAME_HEIGHT: prdata = {{(DATA_W - FH_W){1'b0}}, height_q};
			default:          prdata = '0;
		endcase
	end

	// Any register write restarts the frame.
	assign cfg.restart = wr_en;
	assign cfg.wm1     = wm1_q;
	assign cfg.hm1     = hm1_q;

endmodule

// ----- rtl/ipc_datapath.sv -----
// Position counters, the two line memories and the pixel judging stage.
module ipc_datapath import ipc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_accept,
	input  logic pixel,
	output logic busy_s1,
	output res_t res
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             last_col_s0;
	logic             last_row_s0;

	logic             valid_s1;
	logic             pixel_s1;
	logic [COL_W-1:0] col_s1;
	logic             first_row_s1;
	logic             last_row_s1;
	logic             last_col_s1;
	logic             up_rd_s1;
	logic             cur_rd_s1;
	logic             fwd_s1;
	logic             fwd_d_s1;

	logic             flag_q;
	logic             left_pixel_q;
	logic             left_alone_q;
	logic             pend_q;
	logic             pend_d_q;

	logic             upper_mem [MAX_WIDTH];
	logic             cur_mem   [MAX_WIDTH];

	logic             cur_we;
	logic [COL_W-1:0] cur_wa;
	logic             cur_wd;

	logic             up;
	logic             below_wait;
	logic             has_left;
	logic             left_settled;
	logic             alone;
	logic             miss_below;
	logic             miss_left;
	logic             miss_self;
	logic             flag_n;
	logic             frame_end;

	assign last_col_s0 = (col_q == cfg.wm1);
	assign last_row_s0 = (row_q == cfg.hm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (last_col_s0) begin
				col_q <= '0;
				row_q <= last_row_s0 ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pixel_s1     <= pixel;
			col_s1       <= col_q;
			first_row_s1 <= (row_q == '0);
			last_row_s1  <= last_row_s0;
			last_col_s1  <= last_col_s0;
		end
	end

	// Upper row: the old entry is read and the new pixel written in the same cycle.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			up_rd_s1        <= upper_mem[col_q];
			upper_mem[col_q] <= pixel;
		end
	end

	// Pending-judgment row: a write to the entry being read this cycle is forwarded.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cur_rd_s1 <= cur_mem[col_q];
			fwd_s1    <= cur_we && (cur_wa == col_q);
			fwd_d_s1  <= cur_wd;
		end
		if (cur_we) begin
			cur_mem[cur_wa] <= cur_wd;
		end
	end

	assign up           = ~first_row_s1 & up_rd_s1;
	assign below_wait   = fwd_s1 ? fwd_d_s1 : cur_rd_s1;
	assign has_left     = (col_s1 != '0);
	// The left registers are clear at column zero, so no column test is needed here.
	assign left_settled = ~pixel_s1 & left_alone_q;
	assign alone        = pixel_s1 & ~up & ~left_pixel_q;
	assign frame_end    = valid_s1 & last_col_s1 & last_row_s1;

	assign miss_below = valid_s1 & ~first_row_s1 & below_wait & ~pixel_s1;
	assign miss_left  = valid_s1 & has_left & last_row_s1 & left_settled;
	assign miss_self  = frame_end & alone;
	assign flag_n     = flag_q & ~(miss_below | miss_left | miss_self);

	// The last column of a wide row settles two entries; the second is written in the next
	// cycle, in which a column-zero pixel, if one follows, has nothing to write.
	always_comb begin
		cur_we = 1'b0;
		cur_wa = col_s1;
		cur_wd = alone;
		if (pend_q) begin
			cur_we = 1'b1;
			cur_wa = cfg.wm1;
			cur_wd = pend_d_q;
		end else if (valid_s1 && has_left) begin
			cur_we = 1'b1;
			cur_wa = col_s1 - 1'b1;
			cur_wd = left_settled;
		end else if (valid_s1 && last_col_s1) begin
			cur_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		pend_d_q <= alone;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			flag_q       <= 1'b1;
			left_pixel_q <= 1'b0;
			left_alone_q <= 1'b0;
			pend_q       <= 1'b0;
		end else if (cfg.restart) begin
			valid_s1     <= 1'b0;
			flag_q       <= 1'b1;
			left_pixel_q <= 1'b0;
			left_alone_q <= 1'b0;
			pend_q       <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
			pend_q   <= valid_s1 & last_col_s1 & has_left;
			if (valid_s1) begin
				flag_q       <= frame_end ? 1'b1 : flag_n;
				left_pixel_q <= last_col_s1 ? 1'b0 : pixel_s1;
				left_alone_q <= last_col_s1 ? 1'b0 : alone;
			end
		end
	end

	assign busy_s1           = valid_s1;
	assign res.vld           = frame_end;
	assign res.all_connected = flag_n;

endmodule

// ----- rtl/ipc_out_buf.sv -----
// Small result queue between the judging stage and the output channel.
module ipc_out_buf import ipc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  res_t                  res,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic                  all_connected,
	output logic [OBUF_CNT_W-1:0] cnt
);

	logic                  q [OBUF_DEPTH];
	logic [OBUF_CNT_W-1:0] cnt_q;
	logic                  pop;
	logic [OBUF_CNT_W-1:0] wr_pos;

	assign pop    = (cnt_q != '0) & ~out_stall;
	assign wr_pos = cnt_q - OBUF_CNT_W'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + OBUF_CNT_W'(res.vld) - OBUF_CNT_W'(pop);
		end
	end

	// Each entry takes the new result or, on a pop, shifts down by one; the last only takes new results.
	always_ff @(posedge clk) begin
		for (int i = 0; i < OBUF_DEPTH - 1; i++) begin
			if (res.vld && (wr_pos == OBUF_CNT_W'(i))) begin
				q[i] <= res.all_connected;
			end else if (pop) begin
				q[i] <= q[i + 1];
			end
		end
		if (res.vld && (wr_pos == OBUF_CNT_W'(OBUF_DEPTH - 1))) begin
			q[OBUF_DEPTH - 1] <= res.all_connected;
		end
	end

	assign out_valid     = (cnt_q != '0);
	assign all_connected = q[0];
	assign cnt           = cnt_q;

endmodule

// ----- rtl/isolated_pixel_check_unit.sv -----
// Isolated pixel check unit: top level with configuration, datapath and result queue.
//
// A binary image enters in raster order, one pixel per transfer on the input channel
// (in_valid, in_stall, pixel). Frame width and height are set through the APB-style port;
// a write to either register restarts the frame. It must be made only while the unit
// is idle; the unit itself does not enforce this. On the last pixel of each frame one
// result transfer leaves on the output channel (out_valid, out_stall, all_connected):
// 1 when every foreground pixel has a foreground up, down, left or right neighbor,
// positions outside the frame counting as background. Throughput is one pixel per cycle
// while the input is not stalled: the upper-row and pending-judgment memories are read
// and written back as pixels are accepted, with forwarding into the registered read.
// A result passes the memory read stage, then the result queue, before it is offered.
// The result queue holds three entries; the input stalls only when the queued results and
// the pixel in flight already take all three, so a receiver that stalls for a while stops
// the input and loses nothing. Reset sets 1024 by 1024 and starts a fresh frame.
// The line memories need no clearing: only entries written in the same frame are used.
module isolated_pixel_check_unit import ipc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               pixel,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               all_connected
);

	cfg_t                  cfg;
	res_t                  res;
	logic                  busy_s1;
	logic                  in_accept;
	logic [OBUF_CNT_W-1:0] obuf_cnt;
	logic [OBUF_CNT_W:0]   committed;

	ipc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Accept only when the queue has room for this pixel's result and the one in flight.
	assign committed = {1'b0, obuf_cnt} + (OBUF_CNT_W + 1)'(busy_s1);
	assign in_stall  = (committed >= (OBUF_CNT_W + 1)'(OBUF_DEPTH));
	assign in_accept = in_valid & ~in_stall;

	ipc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_accept (in_accept),
		.pixel     (pixel),
		.busy_s1   (busy_s1),
		.res       (res)
	);

	ipc_out_buf u_obuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.res           (res),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.all_connected (all_connected),
		.cnt           (obuf_cnt)
	);

endmodule
